// File: src/pmel_pkg.sv
// ----------------------------------------------------------------------------
// pmel_pkg: shared types and constants for the buzzer tone/melody sequencer
// Holds the request/result structs, opcodes, widths and the small helpers
// that turn a divider quotient into PWM wrap and level values.
// ----------------------------------------------------------------------------
package pmel_pkg;

  // Note table depth
  localparam int TABLE_DEPTH = 16;
  localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths
  localparam int OP_W   = 3;
  localparam int SLOT_W = 4;
  localparam int HZ_W   = 16;
  localparam int MS_W   = 16;
  localparam int LEN_W  = 5;
  localparam int WRAP_W = 16;
  localparam int IDX_W  = 5;
  localparam int CLK_W  = 28;

  // Table entry: frequency above duration
  localparam int NOTE_W = HZ_W + MS_W;

  // Clock prescale by 16 is a right shift of the clock value
  localparam int DIV_SHIFT = 4;
  localparam int DIVD_W    = CLK_W - DIV_SHIFT;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  localparam logic [CLK_W-1:0]  CLK_RESET = CLK_W'(125000000);
  localparam logic [WRAP_W-1:0] WRAP_MAX  = '1;
  localparam logic [WRAP_W-1:0] HALF_FULL = {1'b1, {(WRAP_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_MELODY = 3'd2,
    OP_TONE   = 3'd3,
    OP_STOP   = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] note_slot;
    logic [HZ_W-1:0]   tone_hz;
    logic [MS_W-1:0]   dur_ms;
    logic [LEN_W-1:0]  melody_len;
  } req_t;

  typedef struct packed {
    logic [WRAP_W-1:0] pwm_wrap;
    logic [WRAP_W-1:0] pwm_level;
    logic              pwm_on;
    logic              melody_active;
    logic              timer_pending;
    logic [IDX_W-1:0]  position;
  } result_t;

  // Quotient to wrap: q-1, floored at 0, saturated at full scale
  function automatic logic [WRAP_W-1:0] wrap_of(input logic [DIVD_W-1:0] q);
    logic [DIVD_W-1:0] qm;
    qm = q - DIVD_W'(1);
    if (q == '0) begin
      return '0;
    end
    if (qm > DIVD_W'(WRAP_MAX)) begin
      return WRAP_MAX;
    end
    return qm[WRAP_W-1:0];
  endfunction

  // floor(w * 32768 / 65535): w/2, except full scale maps to exactly half
  function automatic logic [WRAP_W-1:0] half_level(input logic [WRAP_W-1:0] w);
    if (w == WRAP_MAX) begin
      return HALF_FULL;
    end
    return {1'b0, w[WRAP_W-1:1]};
  endfunction

endpackage

// File: src/pmel_ram.sv
// ----------------------------------------------------------------------------
// pmel_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pmel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pmel_div.sv
// ----------------------------------------------------------------------------
// pmel_div: bit-serial restoring divider
// Shifts the dividend out one bit per cycle into a narrow remainder and
// builds the quotient one bit per cycle. done_o pulses with the result.
// ----------------------------------------------------------------------------
module pmel_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pmel_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [pmel_pkg::HZ_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [pmel_pkg::DIVD_W-1:0]  quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [pmel_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [pmel_pkg::HZ_W-1:0]     rem_q, rem_d;
  logic [pmel_pkg::HZ_W-1:0]     dvs_q, dvs_d;
  logic [pmel_pkg::DIVD_W-1:0]   quo_q, quo_d;
  logic [pmel_pkg::HZ_W:0]       trial;
  logic [pmel_pkg::HZ_W:0]       diff;
  logic                          ge;

  // One quotient bit per cycle
  always_comb begin
    trial  = {rem_q, quo_q[pmel_pkg::DIVD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[pmel_pkg::HZ_W-1:0] : trial[pmel_pkg::HZ_W-1:0];
      quo_d = {quo_q[pmel_pkg::DIVD_W-2:0], ge};
      cnt_d = cnt_q + pmel_pkg::DIV_CNT_W'(1);
      if (cnt_q == pmel_pkg::DIV_CNT_W'(pmel_pkg::DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: src/pwm_tone_melody_sequencer.sv
// ----------------------------------------------------------------------------
// pwm_tone_melody_sequencer: buzzer tone and melody sequencer
// Holds a note table, counts 1 ms ticks and computes PWM wrap/level values
// for single tones and for melodies played from the table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with strobe_o high, and the receiver
// cannot hold it off. A tick that does not step a melody, a note write, a stop
// and a tone of zero frequency pass through S_EXEC to S_DONE; a melody that
// ends at once passes S_EXEC, S_ADV and S_DONE, and a melody step that reads a
// rest passes S_EXEC, S_ADV, S_RD and S_DONE. Anything that sets a new frequency
// runs the bit-serial divider in S_DIV, one quotient bit per cycle for a 24-bit
// quotient, before S_DONE.
// The system clock register may only be written while busy is low.
// ----------------------------------------------------------------------------
module pwm_tone_melody_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  pmel_pkg::req_t              req_i,
  output logic                        strobe_o,
  output pmel_pkg::result_t           result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pmel_pkg::CLK_W-1:0]  cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_ADV  = 6'b000100,
    S_RD   = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                         state_q, state_d;
  pmel_pkg::req_t                 req_q;
  logic [pmel_pkg::CLK_W-1:0]     clk_hz_q;
  logic [pmel_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [pmel_pkg::IDX_W-1:0]     len_q, len_d;
  logic                           flag_q, flag_d;
  logic                           armed_q, armed_d;
  logic                           is_mel_q, is_mel_d;
  logic [pmel_pkg::MS_W-1:0]      ms_q, ms_d;
  logic [pmel_pkg::WRAP_W-1:0]    wrap_q, wrap_d;
  logic [pmel_pkg::WRAP_W-1:0]    level_q, level_d;
  logic                           enable_q, enable_d;

  logic                           ram_we;
  logic                           ram_re;
  logic [pmel_pkg::NOTE_W-1:0]    ram_rdata;
  logic [pmel_pkg::HZ_W-1:0]      note_hz;
  logic [pmel_pkg::MS_W-1:0]      note_ms;

  logic                           div_start;
  logic [pmel_pkg::HZ_W-1:0]      div_divisor;
  logic                           div_done;
  logic [pmel_pkg::DIVD_W-1:0]    div_quo;
  logic [pmel_pkg::WRAP_W-1:0]    new_wrap;

  logic                           accept;
  logic [pmel_pkg::LEN_W-1:0]     len_sat;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign note_hz     = ram_rdata[pmel_pkg::NOTE_W-1:pmel_pkg::MS_W];
  assign note_ms     = ram_rdata[pmel_pkg::MS_W-1:0];
  assign new_wrap    = pmel_pkg::wrap_of(div_quo);

  // Melody length saturates at the table depth
  always_comb begin
    len_sat = req_q.melody_len;
    if (32'(req_q.melody_len) > pmel_pkg::TABLE_DEPTH) begin
      len_sat = pmel_pkg::LEN_W'(pmel_pkg::TABLE_DEPTH);
    end
  end

  // Note table
  pmel_ram #(
    .WIDTH (pmel_pkg::NOTE_W),
    .DEPTH (pmel_pkg::TABLE_DEPTH),
    .AW    (pmel_pkg::TBL_AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pmel_pkg::TBL_AW'(req_q.note_slot)),
    .wdata_i ({req_q.tone_hz, req_q.dur_ms}),
    .re_i    (ram_re),
    .raddr_i (pmel_pkg::TBL_AW'(idx_q)),
    .rdata_o (ram_rdata)
  );

  // Wrap divider: (clock / 16) / frequency
  pmel_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clk_hz_q[pmel_pkg::CLK_W-1:pmel_pkg::DIV_SHIFT]),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    len_d       = len_q;
    flag_d      = flag_q;
    armed_d     = armed_q;
    is_mel_d    = is_mel_q;
    ms_d        = ms_q;
    wrap_d      = wrap_q;
    level_d     = level_q;
    enable_d    = enable_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    div_divisor = req_q.tone_hz;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (pmel_pkg::op_e'(req_q.op))
          pmel_pkg::OP_TICK: begin
            if (armed_q) begin
              if (ms_q > pmel_pkg::MS_W'(1)) begin
                ms_d = ms_q - pmel_pkg::MS_W'(1);
              end else begin
                ms_d = '0;
                if (is_mel_q) begin
                  state_d = S_ADV;
                end else begin
                  level_d = '0;
                  armed_d = 1'b0;
                end
              end
            end
          end
          pmel_pkg::OP_WRITE: begin
            ram_we = (32'(req_q.note_slot) < pmel_pkg::TABLE_DEPTH);
          end
          pmel_pkg::OP_MELODY: begin
            armed_d = 1'b0;
            len_d   = len_sat;
            idx_d   = '0;
            flag_d  = 1'b1;
            state_d = S_ADV;
          end
          pmel_pkg::OP_TONE: begin
            armed_d  = 1'b1;
            is_mel_d = 1'b0;
            ms_d     = req_q.dur_ms;
            if (req_q.tone_hz != '0) begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end else begin
              level_d = pmel_pkg::half_level(wrap_q);
            end
          end
          pmel_pkg::OP_STOP: begin
            armed_d = 1'b0;
            level_d = '0;
            flag_d  = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_ADV: begin
        if (idx_q >= len_q || 32'(idx_q) >= pmel_pkg::TABLE_DEPTH) begin
          level_d = '0;
          flag_d  = 1'b0;
          armed_d = 1'b0;
          state_d = S_DONE;
        end else begin
          ram_re  = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        idx_d    = idx_q + pmel_pkg::IDX_W'(1);
        armed_d  = 1'b1;
        is_mel_d = 1'b1;
        ms_d     = note_ms;
        if (note_hz != '0) begin
          div_start   = 1'b1;
          div_divisor = note_hz;
          state_d     = S_DIV;
        end else begin
          level_d = '0;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          wrap_d   = new_wrap;
          level_d  = pmel_pkg::half_level(new_wrap);
          enable_d = 1'b1;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      clk_hz_q <= pmel_pkg::CLK_RESET;
      idx_q    <= '0;
      len_q    <= '0;
      flag_q   <= 1'b0;
      armed_q  <= 1'b0;
      is_mel_q <= 1'b0;
      ms_q     <= '0;
      wrap_q   <= '0;
      level_q  <= '0;
      enable_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      len_q    <= len_d;
      flag_q   <= flag_d;
      armed_q  <= armed_d;
      is_mel_q <= is_mel_d;
      ms_q     <= ms_d;
      wrap_q   <= wrap_d;
      level_q  <= level_d;
      enable_q <= enable_d;
      if (cfg_valid_i && cfg_ready_o) begin
        clk_hz_q <= cfg_data_i;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // Result ports
  assign busy                   = (state_q != S_IDLE);
  assign strobe_o               = (state_q == S_DONE);
  assign result_o.pwm_wrap      = wrap_q;
  assign result_o.pwm_level     = level_q;
  assign result_o.pwm_on        = enable_q;
  assign result_o.melody_active = flag_q;
  assign result_o.timer_pending = armed_q;
  assign result_o.position      = idx_q;

  // Checks
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result strobe held for more than one cycle");

  a_level_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q != '0) |-> enable_q)
    else $error("nonzero level while PWM never enabled");

  a_melody_timer_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q && is_mel_q) |-> flag_q)
    else $error("melody timeout armed without active melody");

  a_position_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= len_q)
    else $error("melody position beyond melody length");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside of wait state");

endmodule
